@@ sv/vn4_pkg.sv @@
// ----------------------------------------------------------------------------
// vn4_pkg: shared definitions for the 4D value noise block
// Command codes and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package vn4_pkg;

  localparam logic [1:0] CMD_EVAL  = 2'd0;
  localparam logic [1:0] CMD_VALUE = 2'd1;
  localparam logic [1:0] CMD_PERM  = 2'd2;

  // Control and load payload of one item in a pipeline stage.
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic [15:0] nval;
    logic [7:0]  pval;
  } ctrl_t;

endpackage

@@ sv/value_noise_4d.sv @@
// ----------------------------------------------------------------------------
// value_noise_4d: four-dimensional lattice value noise
// Hashes the 16 lattice corners through the permutation table and blends
// the looked-up values by quadrilinear interpolation.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. An
// evaluate item gives its result on noise_out with done high; load items
// give no result. The result passes through the four chained permutation
// lookups, the value lookup (each a memory with a registered read) and the
// four blend levels. Each table is kept as one copy per lookup place; a
// load reaches each copy as it passes that stage, so loads and evaluates
// act strictly in the order they arrive. Both tables must be loaded before
// the first evaluate.
module value_noise_4d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic signed [31:0]  coord_t,
  input  logic [7:0]          entry_index,
  input  logic signed [15:0]  noise_entry,
  input  logic [7:0]          perm_entry,
  output logic                done,
  output logic signed [15:0]  noise_out
);
  import vn4_pkg::*;

  localparam int IB     = $clog2(TABLE_SIZE);
  localparam int VW     = VALUE_BITS;
  localparam int LB     = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int STAGES = 10;

  // Pipeline control and per-item coordinates.
  ctrl_t                ctrl_q [STAGES];
  logic [IB-1:0]        lat_q  [STAGES][4];
  logic [FRAC_BITS-1:0] frac_q [STAGES][4];

  logic [7:0]          ht [2];
  logic [7:0]          hz [4];
  logic [7:0]          hy [8];
  logic [7:0]          hx [16];
  logic signed [VW-1:0] vv [16];
  logic signed [VW-1:0] bx [8];
  logic signed [VW-1:0] by [4];
  logic signed [VW-1:0] bz [2];
  logic signed [VW-1:0] res;

  logic [IB-1:0]        widx [5];
  logic [VW-1:0]        wval;

  assign busy = 1'b0;

  // One blend a + floor(f * (b - a) / 2^FRAC_BITS).
  function automatic logic signed [VW-1:0] blend(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b,
                                                 input logic [FRAC_BITS-1:0] f);
    logic signed [VW:0]           d;
    logic signed [VW+FRAC_BITS+1:0] p;
    d = (VW+1)'(b) - (VW+1)'(a);
    p = d * $signed({1'b0, f});
    return a + VW'(p >>> FRAC_BITS);
  endfunction

  // Input stage and pipeline shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        ctrl_q[s].valid <= 1'b0;
      end
    end else begin
      ctrl_q[0].valid <= start;
      for (int s = 1; s < STAGES; s++) begin
        ctrl_q[s].valid <= ctrl_q[s-1].valid;
      end
    end
    ctrl_q[0].cmd  <= command;
    ctrl_q[0].idx  <= entry_index;
    ctrl_q[0].nval <= noise_entry;
    ctrl_q[0].pval <= perm_entry;
    lat_q[0][0]  <= IB'(coord_x >>> FRAC_BITS);
    lat_q[0][1]  <= IB'(coord_y >>> FRAC_BITS);
    lat_q[0][2]  <= IB'(coord_z >>> FRAC_BITS);
    lat_q[0][3]  <= IB'(coord_t >>> FRAC_BITS);
    frac_q[0][0] <= coord_x[FRAC_BITS-1:0];
    frac_q[0][1] <= coord_y[FRAC_BITS-1:0];
    frac_q[0][2] <= coord_z[FRAC_BITS-1:0];
    frac_q[0][3] <= coord_t[FRAC_BITS-1:0];
    for (int s = 1; s < STAGES; s++) begin
      ctrl_q[s].cmd  <= ctrl_q[s-1].cmd;
      ctrl_q[s].idx  <= ctrl_q[s-1].idx;
      ctrl_q[s].nval <= ctrl_q[s-1].nval;
      ctrl_q[s].pval <= ctrl_q[s-1].pval;
      lat_q[s]  <= lat_q[s-1];
      frac_q[s] <= frac_q[s-1];
    end
  end

  // Write address of each lookup stage, and the sign-extended load value.
  always_comb begin
    for (int s = 0; s < 5; s++) begin
      widx[s] = IB'(ctrl_q[s].idx);
    end
    wval = VW'($signed(ctrl_q[4].nval[LB-1:0]));
  end

  // Permutation lookups: t, then z, y and x, one level per stage.
  genvar j;
  generate
    for (j = 0; j < 2; j++) begin : g_t
      vn4_ram #(.WIDTH(8), .ADDR_BITS(IB)) u_ram (
        .clk   (clk),
        .we    (ctrl_q[0].valid && ctrl_q[0].cmd == CMD_PERM),
        .waddr (widx[0]),
        .wdata (ctrl_q[0].pval),
        .raddr (lat_q[0][3] + IB'(j)),
        .rdata (ht[j])
      );
    end
    for (j = 0; j < 4; j++) begin : g_z
      vn4_ram #(.WIDTH(8), .ADDR_BITS(IB)) u_ram (
        .clk   (clk),
        .we    (ctrl_q[1].valid && ctrl_q[1].cmd == CMD_PERM),
        .waddr (widx[1]),
        .wdata (ctrl_q[1].pval),
        .raddr (lat_q[1][2] + IB'(j % 2) + IB'(ht[j / 2])),
        .rdata (hz[j])
      );
    end
    for (j = 0; j < 8; j++) begin : g_y
      vn4_ram #(.WIDTH(8), .ADDR_BITS(IB)) u_ram (
        .clk   (clk),
        .we    (ctrl_q[2].valid && ctrl_q[2].cmd == CMD_PERM),
        .waddr (widx[2]),
        .wdata (ctrl_q[2].pval),
        .raddr (lat_q[2][1] + IB'(j % 2) + IB'(hz[j / 2])),
        .rdata (hy[j])
      );
    end
    for (j = 0; j < 16; j++) begin : g_x
      vn4_ram #(.WIDTH(8), .ADDR_BITS(IB)) u_ram (
        .clk   (clk),
        .we    (ctrl_q[3].valid && ctrl_q[3].cmd == CMD_PERM),
        .waddr (widx[3]),
        .wdata (ctrl_q[3].pval),
        .raddr (lat_q[3][0] + IB'(j % 2) + IB'(hy[j / 2])),
        .rdata (hx[j])
      );
    end
    // Value lookup for each corner.
    for (j = 0; j < 16; j++) begin : g_v
      vn4_ram #(.WIDTH(VW), .ADDR_BITS(IB)) u_ram (
        .clk   (clk),
        .we    (ctrl_q[4].valid && ctrl_q[4].cmd == CMD_VALUE),
        .waddr (widx[4]),
        .wdata (wval),
        .raddr (IB'(hx[j])),
        .rdata (vv[j])
      );
    end
  endgenerate

  // Blend levels: x, y, z, then t, one level per stage.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      bx[k] <= blend(vv[2*k], vv[2*k+1], frac_q[5][0]);
    end
    for (int k = 0; k < 4; k++) begin
      by[k] <= blend(bx[2*k], bx[2*k+1], frac_q[6][1]);
    end
    for (int k = 0; k < 2; k++) begin
      bz[k] <= blend(by[2*k], by[2*k+1], frac_q[7][2]);
    end
    res <= blend(bz[0], bz[1], frac_q[8][3]);
  end

  assign done      = ctrl_q[9].valid && ctrl_q[9].cmd == CMD_EVAL;
  assign noise_out = 16'(res);

  // Every evaluate item that is taken gives a result.
  a_eval_done: assert property (@(posedge clk) disable iff (rst)
    start && command == CMD_EVAL |-> ##10 done)
    else $error("evaluate item produced no result");

  // A load or unused command gives no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && command != CMD_EVAL |-> ##10 !done)
    else $error("non-evaluate item produced a result");

  // A result is only given for an item that passed the last blend stage.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl_q[8].valid))
    else $error("result without an item in flight");

endmodule

@@ sv/vn4_ram.sv @@
// ----------------------------------------------------------------------------
// vn4_ram: one copy of a lookup table
// Simple dual-port memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vn4_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
